@@ design/pms_pkg.sv @@
// Shared types, constants and state encoding for the pointer motion scaler.
`timescale 1ns / 1ps

package pms_pkg;

	localparam int COORD_BITS_DEFAULT = 12;
	localparam int COUNT_BITS         = 16;
	localparam int FIELD_COORD_BITS   = 12;
	localparam int DIV_BITS           = 3;
	localparam int THRESH_BITS        = 15;
	localparam int FRAC_BITS          = 5;
	localparam int CFG_DATA_BITS      = 15;
	localparam int CFG_INDEX_BITS     = 3;

	localparam logic [DIV_BITS-1:0]    DIV_MAX      = 3'd6;
	localparam logic [DIV_BITS-1:0]    DIV_RESET    = 3'd4;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 15'd10;

	localparam logic KIND_MOTION = 1'b0;
	localparam logic KIND_SET    = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DIVISOR      = 3'd0,
		REG_THRESHOLD    = 3'd1,
		REG_RANGE_LEFT   = 3'd2,
		REG_RANGE_RIGHT  = 3'd3,
		REG_RANGE_TOP    = 3'd4,
		REG_RANGE_BOTTOM = 3'd5
	} pms_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_SIGN,
		S_CARRY,
		S_SCALE,
		S_ADD,
		S_CLAMP_LO,
		S_CLAMP_HI,
		S_DONE
	} pms_state_t;

	typedef struct packed {
		logic                         kind;
		logic signed [COUNT_BITS-1:0] move_x;
		logic signed [COUNT_BITS-1:0] move_y;
		logic [1:0]                   button_bits;
		logic [FIELD_COORD_BITS-1:0]  new_x;
		logic [FIELD_COORD_BITS-1:0]  new_y;
	} pms_in_t;

	typedef struct packed {
		logic [FIELD_COORD_BITS-1:0] col;
		logic [FIELD_COORD_BITS-1:0] row;
		logic                        left_pressed;
		logic                        right_pressed;
	} pms_out_t;

endpackage

@@ design/pointer_motion_scaler.sv @@
// Pointer motion scaler: divides, accumulates, doubles and clamps mouse motion per axis.
`timescale 1ns / 1ps
// Sequence: a motion transfer runs both axes in turn through the sequencer steps, with
// a bit-serial divide on each axis that is skipped when the divisor is zero.
// A set-position transfer goes straight from idle to the final step that loads its result.
// Flow: one item at a time; the next transfer is taken only once the result is loaded and
// the sequencer is back in idle, and a result still unclaimed by the receiver holds it.
// Reset: arst_n clears position, accumulators and handshake state and loads register defaults.

module pointer_motion_scaler #(
	parameter int COORD_BITS = pms_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pms_pkg::pms_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pms_pkg::pms_out_t                   out_data,
	input  logic                                wr_en,
	input  logic [pms_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  logic [pms_pkg::CFG_DATA_BITS-1:0]   wr_data
);

	import pms_pkg::*;

	// The move needs 17 bits signed after the carry and 18 after doubling; one spare bit.
	localparam int MV_BITS = COUNT_BITS + 3;
	// The position sum must hold the unsigned position plus the signed move.
	localparam int P_BITS  = (MV_BITS > COORD_BITS + 1 ? MV_BITS : COORD_BITS + 1) + 1;
	localparam int SUM_BITS = FRAC_BITS + 1;

	// Configuration registers.
	logic [DIV_BITS-1:0]         div_q;
	logic [THRESH_BITS-1:0]      thr_q;
	logic [FIELD_COORD_BITS-1:0] left_q, right_q, top_q, bottom_q;

	// Architectural state.
	logic [COORD_BITS-1:0]       pos_x_q, pos_y_q;
	logic signed [FRAC_BITS-1:0] frac_x_q, frac_y_q;

	// Sequencer and working registers shared by both axes.
	pms_state_t                  state_q, state_d;
	pms_in_t                     item_q;
	logic                        axis_q;     // 0 horizontal, 1 vertical
	logic                        neg_q;
	logic [COUNT_BITS-1:0]       mag_q;      // dividend, then quotient shifted in
	logic [DIV_BITS-1:0]         rem_q;
	logic [3:0]                  cnt_q;
	logic signed [MV_BITS-1:0]   mv_q;
	logic signed [SUM_BITS-1:0]  sum_q;
	logic signed [P_BITS-1:0]    p_q;
	logic                        out_valid_q;
	pms_out_t                    out_q;
	logic                        load_out;

	// Per-axis selections.
	logic signed [COUNT_BITS-1:0]  count_sel;
	logic signed [FRAC_BITS-1:0]   frac_sel;
	logic [COORD_BITS-1:0]         pos_sel;
	logic [FIELD_COORD_BITS-1:0]   lo_sel, hi_sel;

	assign count_sel = axis_q ? item_q.move_y : item_q.move_x;
	assign frac_sel  = axis_q ? frac_y_q : frac_x_q;
	assign pos_sel   = axis_q ? pos_y_q : pos_x_q;
	assign lo_sel    = axis_q ? top_q : left_q;
	assign hi_sel    = axis_q ? bottom_q : right_q;

	// The divide step: shift one dividend bit into the partial remainder and
	// subtract the divisor when it fits.
	logic [DIV_BITS:0]   trial;
	logic                fits;
	logic [DIV_BITS:0]   trial_diff;

	assign trial      = {rem_q, mag_q[COUNT_BITS-1]};
	assign fits       = trial >= {1'b0, div_q};
	assign trial_diff = trial - {1'b0, div_q};

	// Operands of the later steps.
	logic signed [SUM_BITS-1:0] rem_signed;
	logic signed [SUM_BITS-1:0] div_signed;
	logic signed [MV_BITS-1:0]  mag_ext;
	logic signed [MV_BITS-1:0]  mv_abs;
	logic signed [MV_BITS-1:0]  thr_ext;
	logic signed [P_BITS-1:0]   lo_ext, hi_ext;
	logic signed [SUM_BITS-1:0] sum_less, sum_more;

	assign rem_signed = neg_q ? -$signed({{(SUM_BITS-DIV_BITS){1'b0}}, rem_q})
	                          :  $signed({{(SUM_BITS-DIV_BITS){1'b0}}, rem_q});
	assign div_signed = $signed({{(SUM_BITS-DIV_BITS){1'b0}}, div_q});
	assign mag_ext    = $signed({{(MV_BITS-COUNT_BITS){1'b0}}, mag_q});
	assign mv_abs     = mv_q[MV_BITS-1] ? -mv_q : mv_q;
	assign thr_ext    = $signed({{(MV_BITS-THRESH_BITS){1'b0}}, thr_q});
	assign lo_ext     = $signed({{(P_BITS-FIELD_COORD_BITS){1'b0}}, lo_sel});
	assign hi_ext     = $signed({{(P_BITS-FIELD_COORD_BITS){1'b0}}, hi_sel});
	assign sum_less   = sum_q - div_signed;
	assign sum_more   = sum_q + div_signed;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration writes. A divisor above the largest supported value saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= DIV_RESET;
			thr_q    <= THRESH_RESET;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DIVISOR:      div_q    <= (wr_data[DIV_BITS-1:0] > DIV_MAX) ? DIV_MAX
				                                                             : wr_data[DIV_BITS-1:0];
				REG_THRESHOLD:    thr_q    <= wr_data[THRESH_BITS-1:0];
				REG_RANGE_LEFT:   left_q   <= wr_data[FIELD_COORD_BITS-1:0];
				REG_RANGE_RIGHT:  right_q  <= wr_data[FIELD_COORD_BITS-1:0];
				REG_RANGE_TOP:    top_q    <= wr_data[FIELD_COORD_BITS-1:0];
				REG_RANGE_BOTTOM: bottom_q <= wr_data[FIELD_COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. Each axis runs load, divide, sign, carry, scale, add and two clamp
	// steps; the divide is skipped when the divisor is zero.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.kind == KIND_SET) ? S_DONE : S_LOAD;
				end
			end
			S_LOAD:     state_d = (div_q == '0) ? S_SIGN : S_DIV;
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_SIGN;
				end
			end
			S_SIGN:     state_d = S_CARRY;
			S_CARRY:    state_d = S_SCALE;
			S_SCALE:    state_d = S_ADD;
			S_ADD:      state_d = S_CLAMP_LO;
			S_CLAMP_LO: state_d = S_CLAMP_HI;
			S_CLAMP_HI: state_d = axis_q ? S_DONE : S_LOAD;
			S_DONE: begin
				// The result waits here only while the previous one is still unclaimed.
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Position, accumulators and axis select, all cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			frac_x_q <= '0;
			frac_y_q <= '0;
			axis_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					axis_q <= 1'b0;
					if (in_valid && in_data.kind == KIND_SET) begin
						pos_x_q <= COORD_BITS'(in_data.new_x);
						pos_y_q <= COORD_BITS'(in_data.new_y);
					end
				end
				S_CARRY: begin
					// Carry one unit out of the accumulator once it passes the divisor.
					if (sum_q > div_signed) begin
						if (axis_q) frac_y_q <= sum_less[FRAC_BITS-1:0];
						else        frac_x_q <= sum_less[FRAC_BITS-1:0];
					end else if (sum_q < -div_signed) begin
						if (axis_q) frac_y_q <= sum_more[FRAC_BITS-1:0];
						else        frac_x_q <= sum_more[FRAC_BITS-1:0];
					end else begin
						if (axis_q) frac_y_q <= sum_q[FRAC_BITS-1:0];
						else        frac_x_q <= sum_q[FRAC_BITS-1:0];
					end
				end
				S_CLAMP_HI: begin
					// After the low clamp, the high bound wins.
					if (axis_q) begin
						pos_y_q <= (p_q > hi_ext) ? COORD_BITS'(hi_sel) : p_q[COORD_BITS-1:0];
					end else begin
						pos_x_q <= (p_q > hi_ext) ? COORD_BITS'(hi_sel) : p_q[COORD_BITS-1:0];
					end
					axis_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Working registers of the shared arithmetic path; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_q <= in_data;
				end
			end
			S_LOAD: begin
				neg_q <= count_sel[COUNT_BITS-1];
				mag_q <= count_sel[COUNT_BITS-1] ? COUNT_BITS'(-count_sel)
				                                 : COUNT_BITS'(count_sel);
				rem_q <= '0;
				cnt_q <= 4'(COUNT_BITS - 1);
			end
			S_DIV: begin
				rem_q <= fits ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
				mag_q <= {mag_q[COUNT_BITS-2:0], fits};
				cnt_q <= cnt_q - 4'd1;
			end
			S_SIGN: begin
				// Truncating division: quotient and remainder both take the count's sign.
				mv_q  <= neg_q ? -mag_ext : mag_ext;
				sum_q <= $signed({frac_sel[FRAC_BITS-1], frac_sel}) + rem_signed;
			end
			S_CARRY: begin
				if (sum_q > div_signed) begin
					mv_q <= mv_q + MV_BITS'(1);
				end else if (sum_q < -div_signed) begin
					mv_q <= mv_q - MV_BITS'(1);
				end
			end
			S_SCALE: begin
				if (mv_abs > thr_ext) begin
					mv_q <= mv_q <<< 1;
				end
			end
			S_ADD: begin
				p_q <= P_BITS'(mv_q) + $signed({{(P_BITS-COORD_BITS){1'b0}}, pos_sel});
			end
			S_CLAMP_LO: begin
				if (p_q < lo_ext) begin
					p_q <= lo_ext;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a finished result until the transfer completes.
	logic [15:0] col_wide, row_wide;

	assign col_wide = 16'(pos_x_q);
	assign row_wide = 16'(pos_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.col           <= col_wide[FIELD_COORD_BITS-1:0];
			out_q.row           <= row_wide[FIELD_COORD_BITS-1:0];
			out_q.left_pressed  <= item_q.button_bits[0];
			out_q.right_pressed <= item_q.button_bits[1];
		end
	end

	// The accumulators never leave the band that the carry step keeps them in.
	a_frac_band: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(frac_x_q) >= -11) && ($signed(frac_x_q) <= 11) &&
		($signed(frac_y_q) >= -11) && ($signed(frac_y_q) <= 11))
		else $error("remainder accumulator outside its band");

	// A set-position transfer loads the position directly and heads for the result.
	a_set_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.kind == KIND_SET) |=>
		(state_q == S_DONE) && (pos_x_q == COORD_BITS'($past(in_data.new_x))) &&
		(pos_y_q == COORD_BITS'($past(in_data.new_y))))
		else $error("set position not loaded");

	// A new result appears only out of the final sequencer step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside the final step");

endmodule

@@ verif/tb.sv @@
// Testbench for pointer_motion_scaler: directed table, random phases, predictor-based checks.
`timescale 1ns / 1ps

module tb;
	import pms_pkg::*;

	// Indexes past the last register. Writes to them must leave every setting alone.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

	// This tail outlasts a motion transfer inside the block, so it is long enough
	// for a stray extra result to show up after the last expected one.
	localparam int TAIL_CYCLES   = 60;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 200;
	// After this many results, the receiver refuses results for a long stretch.
	localparam int HOLD_AFTER    = 300;
	localparam int HOLD_CYCLES   = 600;

	typedef enum bit {
		ROW_REG,
		ROW_ITEM
	} row_kind_t;

	// One row of the directed table. It is either a register write or an input
	// transfer. A transfer row may carry an expected result typed in by hand.
	typedef struct {
		row_kind_t               kind;
		logic [CFG_INDEX_BITS-1:0] idx;
		int                      val;
		pms_in_t                 item;
		bit                      typed;
		pms_out_t                want;
	} stim_row_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	pms_in_t                   in_data  = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	pms_out_t                  out_data;
	logic                      wr_en    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] wr_index = '0;
	logic [CFG_DATA_BITS-1:0]  wr_data  = '0;

	pointer_motion_scaler u_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.wr_en,
		.wr_index,
		.wr_data
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the block's settings and state, kept in step with each
	// accepted transfer and each register write.
	int cfg_div    = int'(DIV_RESET);
	int cfg_thresh = int'(THRESH_RESET);
	int lim_left   = 0;
	int lim_right  = 0;
	int lim_top    = 0;
	int lim_bottom = 0;
	int cur_x      = 0;
	int cur_y      = 0;
	int acc_x      = 0;
	int acc_y      = 0;

	// Cursor results that have been predicted but not yet seen at the output.
	pms_out_t  pending_cursor[$];
	stim_row_t plan[$];

	int mismatch_count  = 0;
	int results_checked = 0;
	int items_sent      = 0;
	int regs_written    = 0;

	// Receiver pattern state.
	int  ready_mode      = 0;
	int  ready_mode_left = 0;
	int  hold_left       = 0;
	bit  hold_done       = 1'b0;

	// One axis: divide with truncation toward zero, fold the remainder into the
	// accumulator, carry one unit when it passes the divisor, double large moves
	// and clamp low first and high last. Plain 32-bit ints keep it from wrapping.
	function automatic int scale_axis(input int count, inout int acc, input int pos,
			input int lo, input int hi);
		int mv;
		int mag;
		int p;
		mv = count;
		if (cfg_div != 0) begin
			acc = acc + count % cfg_div;
			mv  = count / cfg_div;
		end
		// With a divisor of zero this still runs, so a leftover accumulator
		// nudges every motion by one unit without ever draining.
		if (acc > cfg_div) begin
			mv  = mv + 1;
			acc = acc - cfg_div;
		end else if (acc < -cfg_div) begin
			mv  = mv - 1;
			acc = acc + cfg_div;
		end
		mag = (mv < 0) ? -mv : mv;
		if (mag > cfg_thresh)
			mv = mv * 2;
		p = pos + mv;
		if (p < lo)
			p = lo;
		if (p > hi)
			p = hi;
		return p & 32'hFFF;
	endfunction

	function automatic pms_out_t next_cursor(input pms_in_t it);
		pms_out_t res;
		if (it.kind == KIND_SET) begin
			// A load is taken as it is, with no clamping and no effect on the accumulators.
			cur_x = int'(it.new_x);
			cur_y = int'(it.new_y);
		end else begin
			cur_x = scale_axis($signed(it.move_x), acc_x, cur_x, lim_left, lim_right);
			cur_y = scale_axis($signed(it.move_y), acc_y, cur_y, lim_top, lim_bottom);
		end
		res.col           = cur_x[FIELD_COORD_BITS-1:0];
		res.row           = cur_y[FIELD_COORD_BITS-1:0];
		res.left_pressed  = it.button_bits[0];
		res.right_pressed = it.button_bits[1];
		return res;
	endfunction

	function automatic void note_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input int val);
		case (idx)
			REG_DIVISOR:      cfg_div    = (val[2:0] > DIV_MAX) ? int'(DIV_MAX) : int'(val[2:0]);
			REG_THRESHOLD:    cfg_thresh = val & 32'h7FFF;
			REG_RANGE_LEFT:   lim_left   = val & 32'hFFF;
			REG_RANGE_RIGHT:  lim_right  = val & 32'hFFF;
			REG_RANGE_TOP:    lim_top    = val & 32'hFFF;
			REG_RANGE_BOTTOM: lim_bottom = val & 32'hFFF;
			default: ;
		endcase
	endfunction

	function automatic pms_in_t motion_item(input int mx, input int my, input logic [1:0] btn);
		pms_in_t it;
		it.kind        = KIND_MOTION;
		it.move_x      = mx[COUNT_BITS-1:0];
		it.move_y      = my[COUNT_BITS-1:0];
		it.button_bits = btn;
		// The load fields are unused here, but they still get random bits.
		it.new_x       = FIELD_COORD_BITS'($urandom_range(0, 4095));
		it.new_y       = FIELD_COORD_BITS'($urandom_range(0, 4095));
		return it;
	endfunction

	function automatic pms_in_t set_item(input int x, input int y, input logic [1:0] btn);
		pms_in_t it;
		it.kind        = KIND_SET;
		it.move_x      = COUNT_BITS'($urandom_range(0, 65535));
		it.move_y      = COUNT_BITS'($urandom_range(0, 65535));
		it.button_bits = btn;
		it.new_x       = x[FIELD_COORD_BITS-1:0];
		it.new_y       = y[FIELD_COORD_BITS-1:0];
		return it;
	endfunction

	function automatic stim_row_t row_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
		stim_row_t r;
		r       = '{kind: ROW_REG, idx: idx, val: val, item: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t row_item(input pms_in_t it);
		stim_row_t r;
		r = '{kind: ROW_ITEM, idx: '0, val: 0, item: it, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t row_typed(input pms_in_t it, input int c, input int rw,
			input logic [1:0] btn);
		stim_row_t r;
		r = '{kind: ROW_ITEM, idx: '0, val: 0, item: it, typed: 1'b1, want: '0};
		r.want.col           = c[FIELD_COORD_BITS-1:0];
		r.want.row           = rw[FIELD_COORD_BITS-1:0];
		r.want.left_pressed  = btn[0];
		r.want.right_pressed = btn[1];
		return r;
	endfunction

	// Motion counts: mostly small, so the accumulators and the threshold matter,
	// with a share of medium, full-range and extreme values.
	function automatic int rand_count();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return $urandom_range(0, 40) - 20;
		else if (pick < 7)
			return $urandom_range(0, 1200) - 600;
		else if (pick < 9)
			return $urandom_range(0, 65535) - 32768;
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return -1;
			3: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic pms_in_t random_item();
		logic [1:0] btn;
		btn = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			return set_item(rand_coord(), rand_coord(), btn);
		return motion_item(rand_count(), rand_count(), btn);
	endfunction

	// Bounds for one axis: full span, ordered, inverted, a single point, or a
	// narrow window.
	task automatic pick_bounds(output int lo, output int hi);
		int a;
		int b;
		a = rand_coord();
		b = rand_coord();
		case ($urandom_range(0, 4))
			0: begin
				lo = 0;
				hi = 4095;
			end
			1: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			2: begin
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			3: begin
				lo = a;
				hi = a;
			end
			default: begin
				a  = $urandom_range(100, 3995);
				lo = a - $urandom_range(0, 100);
				hi = a + $urandom_range(0, 100);
			end
		endcase
	endtask

	// One register write. The enable drops for a cycle afterwards so that
	// back-to-back writes never assign it twice in one time step.
	task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[CFG_DATA_BITS-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		note_reg_write(idx, val);
		regs_written++;
		@(posedge clk);
	endtask

	// Stop offering transfers and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_cursor.size() != 0)
			@(posedge clk);
	endtask

	// Offer one transfer and hold it until it is taken. The prediction is made
	// at the accepting edge, against the settings that are live then.
	task automatic push_item(input pms_in_t item, input bit typed, input pms_out_t want);
		pms_out_t predicted;
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = next_cursor(item);
		pending_cursor.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic program_settings(input int phase);
		int div;
		int thresh;
		int left;
		int right;
		int top;
		int bottom;
		div = $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0: thresh = 0;
			1: thresh = 32767;
			2: thresh = $urandom_range(0, 64);
			default: thresh = $urandom_range(0, 32767);
		endcase
		pick_bounds(left, right);
		pick_bounds(top, bottom);
		// The first two phases use the full screen so the cursor roams freely,
		// once at the largest divisor and once with division off.
		if (phase < 2) begin
			div    = (phase == 0) ? 6 : 0;
			left   = 0;
			right  = 4095;
			top    = 0;
			bottom = 4095;
		end
		reg_write(REG_DIVISOR, div);
		reg_write(REG_THRESHOLD, thresh);
		reg_write(REG_RANGE_LEFT, left);
		reg_write(REG_RANGE_RIGHT, right);
		reg_write(REG_RANGE_TOP, top);
		reg_write(REG_RANGE_BOTTOM, bottom);
		if ($urandom_range(0, 2) == 0)
			reg_write(REG_SPARE_7, $urandom_range(0, 32767));
	endtask

	// Result checker and receiver in one process, so that the stall pattern can
	// depend on the result count without a race between processes.
	always @(posedge clk) begin
		pms_out_t want;
		bit       bad;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cursor.size() == 0) begin
				$display("%0t: result with nothing expected, got col %0d row %0d buttons %b%b",
					$time, out_data.col, out_data.row, out_data.right_pressed,
					out_data.left_pressed);
				mismatch_count++;
			end else begin
				want = pending_cursor.pop_front();
				bad  = 1'b0;
				if (out_data.col != want.col) begin
					$display("%0t: col expected %0d, got %0d", $time, want.col, out_data.col);
					bad = 1'b1;
				end
				if (out_data.row != want.row) begin
					$display("%0t: row expected %0d, got %0d", $time, want.row, out_data.row);
					bad = 1'b1;
				end
				if (out_data.left_pressed != want.left_pressed) begin
					$display("%0t: left_pressed expected %b, got %b", $time,
						want.left_pressed, out_data.left_pressed);
					bad = 1'b1;
				end
				if (out_data.right_pressed != want.right_pressed) begin
					$display("%0t: right_pressed expected %b, got %b", $time,
						want.right_pressed, out_data.right_pressed);
					bad = 1'b1;
				end
				if (bad)
					mismatch_count++;
			end
			results_checked++;
		end

		// Once, a long refusal while the sender keeps offering, so the block
		// fills and stalls its input. Otherwise the receiver switches between
		// always ready, coin-flip and mostly stalled, each for a random stretch.
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_checked >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (ready_mode_left == 0) begin
				ready_mode      = $urandom_range(0, 2);
				ready_mode_left = $urandom_range(20, 200);
			end else begin
				ready_mode_left--;
			end
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		int burst_left;
		int gap;
		burst_left = 0;

		// Directed table. It starts on the reset settings: divisor 4, threshold
		// 10 and every bound at zero, so motion pins the cursor to the origin.
		plan.push_back(row_typed(motion_item(32767, -32768, 2'b00), 0, 0, 2'b00));
		// A load ignores the bounds entirely.
		plan.push_back(row_typed(set_item(4095, 4095, 2'b11), 4095, 4095, 2'b11));
		plan.push_back(row_typed(motion_item(0, 0, 2'b01), 0, 0, 2'b01));
		plan.push_back(row_typed(set_item(2048, 1, 2'b10), 2048, 1, 2'b10));
		// Full screen: the largest counts, doubled, slam into both edges.
		plan.push_back(row_reg(REG_RANGE_LEFT, 0));
		plan.push_back(row_reg(REG_RANGE_RIGHT, 4095));
		plan.push_back(row_reg(REG_RANGE_TOP, 0));
		plan.push_back(row_reg(REG_RANGE_BOTTOM, 4095));
		plan.push_back(row_typed(motion_item(-32768, 32767, 2'b11), 0, 4095, 2'b11));
		// A divisor write of 7 saturates to 6; small moves build up remainders.
		plan.push_back(row_reg(REG_DIVISOR, 7));
		plan.push_back(row_item(motion_item(13, -13, 2'b00)));
		plan.push_back(row_item(motion_item(5, 5, 2'b01)));
		plan.push_back(row_item(motion_item(-5, -5, 2'b10)));
		plan.push_back(row_item(motion_item(1, -1, 2'b11)));
		// Divisor zero with leftover remainders: every move gets nudged.
		plan.push_back(row_reg(REG_DIVISOR, 0));
		plan.push_back(row_item(motion_item(0, 0, 2'b00)));
		plan.push_back(row_item(motion_item(0, 0, 2'b01)));
		plan.push_back(row_item(motion_item(3, -3, 2'b10)));
		// Highest threshold with divisor 1: 32767 stays single, -32768 doubles.
		plan.push_back(row_reg(REG_THRESHOLD, 32767));
		plan.push_back(row_reg(REG_DIVISOR, 1));
		plan.push_back(row_item(set_item(2048, 2048, 2'b00)));
		plan.push_back(row_item(motion_item(32767, -32768, 2'b01)));
		// Threshold zero doubles every nonzero move.
		plan.push_back(row_reg(REG_THRESHOLD, 0));
		plan.push_back(row_item(motion_item(1, -1, 2'b10)));
		// Writes past the register list must change nothing.
		plan.push_back(row_reg(REG_SPARE_6, 0));
		plan.push_back(row_reg(REG_SPARE_7, 32767));
		plan.push_back(row_item(motion_item(-2, 2, 2'b11)));
		// Inverted bounds: the high bound wins, whatever the move.
		plan.push_back(row_reg(REG_RANGE_LEFT, 3000));
		plan.push_back(row_reg(REG_RANGE_RIGHT, 1000));
		plan.push_back(row_reg(REG_RANGE_TOP, 4000));
		plan.push_back(row_reg(REG_RANGE_BOTTOM, 5));
		plan.push_back(row_typed(motion_item(0, 0, 2'b00), 1000, 5, 2'b00));
		plan.push_back(row_typed(set_item(4095, 0, 2'b01), 4095, 0, 2'b01));
		plan.push_back(row_typed(motion_item(-32768, 32767, 2'b10), 1000, 5, 2'b10));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				drain();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				push_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// Random phases. Each starts from an idle block with fresh settings;
		// the sender then works in bursts with random gaps, some of them zero.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			program_settings(phase);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				push_item(random_item(), 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d transfers and checked %0d cursor results, with %0d register writes.",
			items_sent, results_checked, regs_written);
		$display("Covered loads, divisors 0 to 6, threshold extremes and inverted bounds.");
		if (mismatch_count == 0 && pending_cursor.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#15_000_000;
		$display("Timed out with %0d results still outstanding.", pending_cursor.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
